>>> rtl/frame_rotator_90_180_270_macros.svh
// Assertion macros for the frame rotator RTL.
`ifndef FRAME_ROTATOR_90_180_270_MACROS_SVH
`define FRAME_ROTATOR_90_180_270_MACROS_SVH

`ifndef SYNTHESIS
`define FROT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FROT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FROT_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define FROT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/frot_pkg.sv
`timescale 1ns / 1ps

package frot_pkg;

  localparam int PixelW   = 32;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 2;

  localparam int DefMaxPixels = 65536;
  localparam int DefMaxDim    = 1024;

  localparam logic [CfgIdxW-1:0] RegOutWidth     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutHeight    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRotationMode = 2'd2;

  localparam logic [1:0] RotNone = 2'd0;
  localparam logic [1:0] Rot90   = 2'd1;
  localparam logic [1:0] Rot180  = 2'd2;
  localparam logic [1:0] Rot270  = 2'd3;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdFetch = 1'b1;

endpackage

>>> rtl/frame_rotator_90_180_270.sv
`timescale 1ns / 1ps
// Frame rotator: turns an RGBA picture clockwise by 0, 90, 180 or 270 degrees.
// Input stream: tuser selects the word kind (0 load, 1 fetch), tdata carries
// the source pixel of a load. Loads fill the frame store in source raster
// order; each fetch returns the next pixel of the rotated frame on the output
// stream, with tlast on the final pixel of the frame.
// A load leaves the block idle, so the next word is accepted in the following cycle.
// A fetch passes through four steps (accept, address multiply, store read,
// output register), and no new word is accepted until its result has
// entered the output register.
// The rate is set by the single-port read path of the frame store and the
// sy * width multiply that forms the source address.
// Writes to width, height or rotation restart the load and fetch pointers;
// every config write drops tready next cycle while the pixel count settles.
// Reset clears the pointers and sets a 1 x 1 frame with no rotation; the
// frame store is not cleared and must be loaded before it is fetched.
// When the receiver stalls, the result waits in the output register; loads
// are still taken, and a further fetch holds in its last step until the
// register frees up.

`include "frame_rotator_90_180_270_macros.svh"

module frame_rotator_90_180_270 #(
  parameter int MaxPixels = frot_pkg::DefMaxPixels,
  parameter int MaxDim    = frot_pkg::DefMaxDim
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [frot_pkg::PixelW-1:0]     s_axis_tdata,  // pixel_in
  input  logic                            s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [frot_pkg::PixelW-1:0]     m_axis_tdata,  // pixel_out
  output logic                            m_axis_tlast,  // frame_last
  input  logic                            cfg_we_i,
  input  logic [frot_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [frot_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AddrW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;
  localparam int DimW  = $clog2(MaxDim + 1);
  localparam int CrdW  = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int TotW  = $clog2(MaxDim * MaxDim + 1);
  localparam int ProdW = CrdW + DimW;

  typedef enum logic [1:0] {
    SIdle,
    SAddr,
    SRead,
    SResp
  } state_e;

  state_e                      state_q;
  logic                        settle_q;
  logic [DimW-1:0]             width_q;
  logic [DimW-1:0]             height_q;
  logic [1:0]                  mode_q;
  logic [TotW-1:0]             total_q;
  logic [TotW-1:0]             load_index_q;
  logic [CrdW-1:0]             out_col_q;
  logic [CrdW-1:0]             out_row_q;
  logic [CrdW-1:0]             sx_q;
  logic [CrdW-1:0]             sy_q;
  logic                        last_q;
  logic [TotW-1:0]             addr_q;
  logic                        oob_q;
  logic                        out_valid_q;
  logic [frot_pkg::PixelW-1:0] out_data_q;
  logic                        out_last_q;

  logic                        accept;
  logic                        is_load;
  logic                        is_fetch;
  logic                        swap;
  logic [DimW-1:0]             src_w;
  logic [DimW-1:0]             src_h;
  logic [DimW-1:0]             cfg_dim;
  logic [CrdW-1:0]             x;
  logic [CrdW-1:0]             y;
  logic [CrdW-1:0]             sx_d;
  logic [CrdW-1:0]             sy_d;
  logic                        last_d;
  logic [DimW-1:0]             col_inc;
  logic [DimW-1:0]             row_inc;
  logic [TotW-1:0]             load_inc;
  logic [ProdW-1:0]            prod;
  logic                        store_we;
  logic                        store_re;
  logic [frot_pkg::PixelW-1:0] store_rdata;

  assign s_axis_tready = (state_q == SIdle) && !settle_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_load       = accept && (s_axis_tuser == frot_pkg::CmdLoad);
  assign is_fetch      = accept && (s_axis_tuser == frot_pkg::CmdFetch);

  assign swap  = (mode_q == frot_pkg::Rot90) || (mode_q == frot_pkg::Rot270);
  assign src_w = swap ? height_q : width_q;
  assign src_h = swap ? width_q : height_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_dim = DimW'(1);
    end else if (32'(cfg_data_i) > 32'(MaxDim)) begin
      cfg_dim = DimW'(MaxDim);
    end else begin
      cfg_dim = DimW'(cfg_data_i);
    end
  end

  always_comb begin
    if ((DimW'(out_col_q) >= width_q) || (DimW'(out_row_q) >= height_q)) begin
      x = '0;
      y = '0;
    end else begin
      x = out_col_q;
      y = out_row_q;
    end
    case (mode_q)
      frot_pkg::Rot90: begin
        sx_d = y;
        sy_d = CrdW'(src_h - DimW'(1) - DimW'(x));
      end
      frot_pkg::Rot180: begin
        sx_d = CrdW'(src_w - DimW'(1) - DimW'(x));
        sy_d = CrdW'(src_h - DimW'(1) - DimW'(y));
      end
      frot_pkg::Rot270: begin
        sx_d = CrdW'(src_w - DimW'(1) - DimW'(y));
        sy_d = x;
      end
      default: begin
        sx_d = x;
        sy_d = y;
      end
    endcase
    last_d  = (DimW'(x) == width_q - DimW'(1)) && (DimW'(y) == height_q - DimW'(1));
    col_inc = DimW'(x) + DimW'(1);
    row_inc = DimW'(y) + DimW'(1);
  end

  assign load_inc = load_index_q + TotW'(1);
  assign prod     = ProdW'(ProdW'(sy_q) * ProdW'(src_w)) + ProdW'(sx_q);
  assign store_we = is_load && (32'(load_index_q) < 32'(MaxPixels));
  assign store_re = (state_q == SRead);

  frot_store #(
    .Depth(MaxPixels)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(AddrW'(load_index_q)),
    .wdata_i(s_axis_tdata),
    .re_i   (store_re),
    .raddr_i(AddrW'(addr_q)),
    .rdata_o(store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      settle_q     <= 1'b0;
      width_q      <= DimW'(1);
      height_q     <= DimW'(1);
      mode_q       <= frot_pkg::RotNone;
      total_q      <= TotW'(1);
      load_index_q <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_valid_q  <= 1'b0;
      sx_q         <= '0;
      sy_q         <= '0;
      last_q       <= 1'b0;
      addr_q       <= '0;
      oob_q        <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      settle_q <= cfg_we_i;
      total_q  <= TotW'(TotW'(width_q) * TotW'(height_q));
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        SIdle: begin
          if (is_load) begin
            load_index_q <= (load_inc >= total_q) ? '0 : load_inc;
          end
          if (is_fetch) begin
            sx_q   <= sx_d;
            sy_q   <= sy_d;
            last_q <= last_d;
            if (col_inc >= width_q) begin
              out_col_q <= '0;
              out_row_q <= (row_inc >= height_q) ? '0 : CrdW'(row_inc);
            end else begin
              out_col_q <= CrdW'(col_inc);
              out_row_q <= y;
            end
            state_q <= SAddr;
          end
        end
        SAddr: begin
          addr_q  <= TotW'(prod);
          state_q <= SRead;
        end
        SRead: begin
          oob_q   <= !(32'(addr_q) < 32'(MaxPixels));
          state_q <= SResp;
        end
        SResp: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= oob_q ? '0 : store_rdata;
            out_last_q  <= last_q;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase

      if (cfg_we_i) begin
        case (cfg_index_i)
          frot_pkg::RegOutWidth:     width_q  <= cfg_dim;
          frot_pkg::RegOutHeight:    height_q <= cfg_dim;
          frot_pkg::RegRotationMode: mode_q   <= cfg_data_i[1:0];
          default: ;
        endcase
        if ((cfg_index_i == frot_pkg::RegOutWidth) ||
            (cfg_index_i == frot_pkg::RegOutHeight) ||
            (cfg_index_i == frot_pkg::RegRotationMode)) begin
          load_index_q <= '0;
          out_col_q    <= '0;
          out_row_q    <= '0;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `FROT_ASSERT_IMPLIES(a_load_in_frame, 1'b1, load_index_q < total_q, "load pointer past frame")
  `FROT_ASSERT_IMPLIES(a_pos_in_frame, 1'b1,
    (DimW'(out_col_q) < width_q) && (DimW'(out_row_q) < height_q), "fetch pointer past frame")
  `FROT_ASSERT_NEXT(a_fetch_starts, is_fetch && !cfg_we_i, state_q == SAddr,
    "fetch did not start address step")
  `FROT_ASSERT_NEXT(a_resp_holds, (state_q == SResp) && out_valid_q && !m_axis_tready,
    (state_q == SResp) && out_valid_q, "result dropped while output stalled")
  `FROT_ASSERT_NEXT(a_last_wraps, is_fetch && last_d && !cfg_we_i,
    (out_col_q == '0) && (out_row_q == '0), "pointer did not wrap after last pixel")

endmodule

>>> rtl/frot_store.sv
`timescale 1ns / 1ps

module frot_store #(
  parameter  int Depth = frot_pkg::DefMaxPixels,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [frot_pkg::PixelW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [frot_pkg::PixelW-1:0]   rdata_o
);

  logic [frot_pkg::PixelW-1:0] mem_q [Depth];
  logic [frot_pkg::PixelW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
